// ===== design/t1bpe_pkg.sv =====
// ----------------------------------------------------------------------------
// T=1 block protocol engine package
// Shared sizes, codes and result kinds.
// ----------------------------------------------------------------------------
package t1bpe_pkg;

  localparam int MAX_INF     = 254;
  localparam int MAX_RETRIES = 2;
  localparam int APDU_DEPTH  = 512;
  localparam int RESP_DEPTH  = 512;

  localparam int APDU_AW = $clog2(APDU_DEPTH);
  localparam int RESP_AW = $clog2(RESP_DEPTH);
  localparam int ECHO_AW = $clog2(MAX_INF);

  // transaction phase
  localparam logic [2:0] PH_LOAD = 3'd0;
  localparam logic [2:0] PH_SEND = 3'd1;
  localparam logic [2:0] PH_RECV = 3'd2;
  localparam logic [2:0] PH_READ = 3'd3;
  localparam logic [2:0] PH_FAIL = 3'd4;

  // frame being sent
  localparam logic [1:0] FR_IBLOCK  = 2'd0;
  localparam logic [1:0] FR_ACK     = 2'd1;
  localparam logic [1:0] FR_ECHO    = 2'd2;
  localparam logic [1:0] FR_RESYNCH = 2'd3;

  // input mode
  localparam logic [1:0] MD_APDU  = 2'd0;
  localparam logic [1:0] MD_CARD  = 2'd1;
  localparam logic [1:0] MD_PULL  = 2'd2;
  localparam logic [1:0] MD_SPARE = 2'd3;

  // result kind
  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_TX   = 3'd1;
  localparam logic [2:0] K_RESP = 3'd2;
  localparam logic [2:0] K_DONE = 3'd3;
  localparam logic [2:0] K_ERR  = 3'd4;

  // config register indexes
  localparam logic REG_IFSC  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // PCB values and masks
  localparam logic [7:0] PCB_RESYNCH_REQ = 8'hC0;
  localparam logic [7:0] PCB_RESYNCH_RSP = 8'hE0;
  localparam logic [7:0] PCB_R_BLOCK     = 8'h80;

endpackage

// ===== design/t1_block_protocol_engine_top.sv =====
// ----------------------------------------------------------------------------
// T=1 block protocol engine, host side
// Loads an APDU, frames it as chained I-blocks, checks card frames, echoes
// S-requests, retries on NAK with one RESYNCH, gathers the response.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: tuser is the mode (APDU byte, card byte, pull),
//   tdata the byte, tlast marks the last APDU byte or last card frame byte.
//   Output stream m_axis_*: every accepted input gives exactly one result:
//   tuser is the kind (nothing, byte to card, response byte, done, error),
//   tdata holds the data byte and the response length (valid with done).
//   The result is registered and valid in the cycle after input acceptance; a
//   new item is taken every cycle unless the receiver stalls. The per-item state
//   update is a single pass of logic after the input handshake; store reads are
//   prefetched from the next state, so each memory port sees one access a cycle.
//   When the receiver stalls, the result register holds and s_axis_tready
//   drops until the result is taken; no item is dropped.
//   Reset (rst, synchronous) returns to the load phase with all counters and
//   sequence bits cleared; the byte stores are not cleared and need no pass.
//   Configuration writes (cfg_wr_en) take effect at once; issue them only
//   while no request is in flight.
// ----------------------------------------------------------------------------
module t1_block_protocol_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  input  logic        s_axis_tlast,   // last_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_out, [17:8] resp_count, rest 0
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast,   // last_out
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [9:0]  cfg_wdata
);
  import t1bpe_pkg::*;

  // configuration
  logic [7:0] ifsc_size;
  logic [9:0] response_limit;

  // state
  logic [9:0] apdu_count, send_offset, response_count, read_index;
  logic       seq_send_saved, seq_recv_saved, seq_send_work, seq_recv_work;
  logic [2:0] retry_count, phase;
  logic       resynch_spent, chained_send;
  logic [1:0] tx_frame_kind;
  logic [7:0] tx_pcb, tx_len, tx_check, rx_pcb, rx_len, rx_check;
  logic [8:0] tx_pos, rx_pos;

  logic [9:0] apdu_count_next, send_offset_next, response_count_next, read_index_next;
  logic       seq_send_saved_next, seq_recv_saved_next;
  logic       seq_send_work_next, seq_recv_work_next;
  logic [2:0] retry_count_next, phase_next;
  logic       resynch_spent_next, chained_send_next;
  logic [1:0] tx_frame_kind_next;
  logic [7:0] tx_pcb_next, tx_len_next, tx_check_next;
  logic [7:0] rx_pcb_next, rx_len_next, rx_check_next;
  logic [8:0] tx_pos_next, rx_pos_next;

  // memories and prefetched read data
  logic [7:0] apdu_mem [APDU_DEPTH];
  logic [7:0] echo_mem [MAX_INF];
  logic [7:0] resp_mem [RESP_DEPTH];
  logic [7:0] apdu_rd, echo_rd, resp_rd;
  logic                apdu_we, echo_we, resp_we;
  logic [APDU_AW-1:0]  apdu_wa, apdu_ra;
  logic [ECHO_AW-1:0]  echo_wa, echo_ra;
  logic [RESP_AW-1:0]  resp_wa, resp_ra;
  logic [7:0]          wr_byte;

  // result register
  logic       accept;
  logic [2:0] res_kind;
  logic [7:0] res_data;
  logic       res_last;
  logic [9:0] res_cnt;

  // combinational helpers
  logic [7:0]  ifsc_now;
  logic [9:0]  cap;
  logic [8:0]  ck_cur;
  logic [9:0]  off_adv;
  logic        fl;
  logic [7:0]  chk;
  logic [8:0]  di, tx_di;
  logic [10:0] resp_sum, need, aaddr_cur, aaddr_next;
  logic [7:0]  tx_data;
  logic        tx_lo, ssw;
  logic [9:0]  rc_new, ri_inc;
  logic [9:0]  ac_v;
  logic [2:0]  ph_v;
  logic [8:0]  ck_blk;
  logic [9:0]  blk_off, blk_cnt;
  logic        blk_seq, blk_go;

  // chunk size: {chained, chunk} for a given count and offset
  function automatic logic [8:0] chunk_calc(input logic [9:0] cnt, input logic [9:0] off,
                                            input logic [7:0] lim);
    logic [9:0] rem;
    logic [7:0] ch;
    rem = (cnt > off) ? (cnt - off) : 10'd0;
    ch  = (rem > {2'b00, lim}) ? lim : rem[7:0];
    return {({2'b00, ch} < rem), ch};
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;

  assign ifsc_now = (ifsc_size == 8'd0) ? 8'd1 :
                    (ifsc_size > 8'(MAX_INF)) ? 8'(MAX_INF) : ifsc_size;
  assign cap      = (response_limit > 10'(RESP_DEPTH)) ? 10'(RESP_DEPTH) : response_limit;
  assign ck_cur   = chunk_calc(apdu_count, send_offset, ifsc_now);
  assign off_adv  = send_offset + {2'b00, ck_cur[7:0]};
  assign need     = {1'b0, response_count} + {3'b000, rx_len};
  assign ri_inc   = read_index + 10'd1;
  assign ck_blk   = chunk_calc(blk_cnt, blk_off, ifsc_now);

  // transmit byte at the current frame position
  always_comb begin
    tx_di     = tx_pos - 9'd3;
    aaddr_cur = {1'b0, send_offset} + {2'b00, tx_di};
    tx_lo     = 1'b0;
    if (tx_pos == 9'd0) begin
      tx_data = 8'd0;
    end else if (tx_pos == 9'd1) begin
      tx_data = tx_pcb;
    end else if (tx_pos == 9'd2) begin
      tx_data = tx_len;
    end else if (tx_pos < 9'd3 + {1'b0, tx_len}) begin
      if (tx_frame_kind == FR_ECHO) begin
        tx_data = (tx_di < 9'(MAX_INF)) ? echo_rd : 8'd0;
      end else begin
        tx_data = (aaddr_cur < 11'(APDU_DEPTH)) ? apdu_rd : 8'd0;
      end
    end else begin
      tx_data = tx_check;
      tx_lo   = 1'b1;
    end
  end

  // one pass of the protocol update
  always_comb begin
    apdu_count_next     = apdu_count;
    send_offset_next    = send_offset;
    response_count_next = response_count;
    read_index_next     = read_index;
    seq_send_saved_next = seq_send_saved;
    seq_recv_saved_next = seq_recv_saved;
    seq_send_work_next  = seq_send_work;
    seq_recv_work_next  = seq_recv_work;
    retry_count_next    = retry_count;
    phase_next          = phase;
    resynch_spent_next  = resynch_spent;
    chained_send_next   = chained_send;
    tx_frame_kind_next  = tx_frame_kind;
    tx_pcb_next         = tx_pcb;
    tx_len_next         = tx_len;
    tx_pos_next         = tx_pos;
    tx_check_next       = tx_check;
    rx_pcb_next         = rx_pcb;
    rx_len_next         = rx_len;
    rx_pos_next         = rx_pos;
    rx_check_next       = rx_check;
    res_kind = K_NONE;
    res_data = 8'd0;
    res_last = 1'b0;
    res_cnt  = 10'd0;
    apdu_we  = 1'b0;
    echo_we  = 1'b0;
    resp_we  = 1'b0;
    apdu_wa  = apdu_count[APDU_AW-1:0];
    echo_wa  = '0;
    resp_wa  = '0;
    wr_byte  = s_axis_tdata;
    blk_go   = 1'b0;
    blk_off  = send_offset;
    blk_cnt  = apdu_count;
    blk_seq  = seq_send_work;
    fl       = 1'b0;
    chk      = rx_check ^ s_axis_tdata;
    di       = rx_pos - 9'd3;
    resp_sum = {1'b0, response_count} + {2'b00, di};
    ssw      = seq_send_work;
    rc_new   = response_count + {2'b00, rx_len};
    ac_v     = apdu_count;
    ph_v     = phase;

    if (accept) begin
      unique case (s_axis_tuser)
        MD_APDU: begin
          if (phase == PH_READ || phase == PH_FAIL) begin
            ac_v = 10'd0;
            ph_v = PH_LOAD;
            apdu_count_next = 10'd0;
            phase_next      = PH_LOAD;
          end
          if (ph_v == PH_LOAD) begin
            if (ac_v >= 10'(APDU_DEPTH)) begin
              fl = 1'b1;
            end else begin
              apdu_we = 1'b1;
              apdu_wa = ac_v[APDU_AW-1:0];
              apdu_count_next = ac_v + 10'd1;
              if (s_axis_tlast) begin
                if (ifsc_size == 8'd0 || ifsc_size > 8'(MAX_INF)) begin
                  fl = 1'b1;
                end else begin
                  seq_send_work_next  = seq_send_saved;
                  seq_recv_work_next  = seq_recv_saved;
                  send_offset_next    = 10'd0;
                  retry_count_next    = 3'd0;
                  resynch_spent_next  = 1'b0;
                  response_count_next = 10'd0;
                  read_index_next     = 10'd0;
                  blk_go  = 1'b1;
                  blk_off = 10'd0;
                  blk_cnt = ac_v + 10'd1;
                  blk_seq = seq_send_saved;
                end
              end
            end
          end
        end
        MD_CARD: begin
          if (phase == PH_RECV) begin
            rx_check_next = chk;
            if (rx_pos == 9'd0) begin
              if (s_axis_tdata != 8'd0) fl = 1'b1;
            end else if (rx_pos == 9'd1) begin
              rx_pcb_next = s_axis_tdata;
            end else if (rx_pos == 9'd2) begin
              if (s_axis_tdata > 8'(MAX_INF)) fl = 1'b1;
              else rx_len_next = s_axis_tdata;
            end else if (di < {1'b0, rx_len}) begin
              echo_we = 1'b1;
              echo_wa = di[ECHO_AW-1:0];
              if (resp_sum < 11'(RESP_DEPTH)) begin
                resp_we = 1'b1;
                resp_wa = resp_sum[RESP_AW-1:0];
              end
            end
            if (!fl) begin
              if (s_axis_tlast) begin
                if (rx_pos < 9'd3 || rx_pos != 9'd3 + {1'b0, rx_len} || chk != 8'd0) begin
                  fl = 1'b1;
                end else if (tx_frame_kind == FR_RESYNCH) begin
                  // resynch answer restarts the exchange
                  if (rx_pcb != PCB_RESYNCH_RSP || rx_len != 8'd0) begin
                    fl = 1'b1;
                  end else begin
                    resynch_spent_next  = 1'b1;
                    retry_count_next    = 3'd0;
                    send_offset_next    = 10'd0;
                    response_count_next = 10'd0;
                    seq_send_work_next  = 1'b0;
                    seq_recv_work_next  = 1'b0;
                    blk_go  = 1'b1;
                    blk_off = 10'd0;
                    blk_seq = 1'b0;
                  end
                end else if (rx_pcb[7:6] == 2'b11 && !rx_pcb[5]) begin
                  // S-request: echo as response
                  tx_frame_kind_next = FR_ECHO;
                  tx_pcb_next   = rx_pcb | 8'h20;
                  tx_len_next   = rx_len;
                  tx_pos_next   = 9'd0;
                  tx_check_next = 8'd0;
                  phase_next    = PH_SEND;
                end else if (send_offset < apdu_count && rx_pcb[7:6] == 2'b10) begin
                  // R-block while sending
                  if (rx_pcb[3:0] != 4'd0) begin
                    if (rx_pcb[4] != seq_send_work) begin
                      fl = 1'b1;
                    end else if (retry_count < 3'(MAX_RETRIES)) begin
                      retry_count_next = retry_count + 3'd1;
                      blk_go = 1'b1;
                    end else if (resynch_spent) begin
                      fl = 1'b1;
                    end else begin
                      tx_frame_kind_next = FR_RESYNCH;
                      tx_pcb_next   = PCB_RESYNCH_REQ;
                      tx_len_next   = 8'd0;
                      tx_pos_next   = 9'd0;
                      tx_check_next = 8'd0;
                      phase_next    = PH_SEND;
                    end
                  end else if (rx_pcb[4] != !seq_send_work || !chained_send) begin
                    fl = 1'b1;
                  end else begin
                    send_offset_next   = off_adv;
                    seq_send_work_next = !seq_send_work;
                    retry_count_next   = 3'd0;
                    blk_go  = 1'b1;
                    blk_off = off_adv;
                    blk_seq = !seq_send_work;
                  end
                end else begin
                  // I-block from card
                  if (rx_pcb[7] || rx_pcb[4:0] != 5'd0 || rx_pcb[6] != seq_recv_work ||
                      need > {1'b0, cap} ||
                      (send_offset < apdu_count && chained_send)) begin
                    fl = 1'b1;
                  end else begin
                    if (send_offset < apdu_count) begin
                      send_offset_next   = off_adv;
                      ssw                = !seq_send_work;
                      seq_send_work_next = ssw;
                    end
                    response_count_next = rc_new;
                    seq_recv_work_next  = !seq_recv_work;
                    if (rx_pcb[5]) begin
                      tx_frame_kind_next = FR_ACK;
                      tx_pcb_next   = PCB_R_BLOCK | {3'b000, !seq_recv_work, 4'h0};
                      tx_len_next   = 8'd0;
                      tx_pos_next   = 9'd0;
                      tx_check_next = 8'd0;
                      phase_next    = PH_SEND;
                    end else begin
                      seq_send_saved_next = ssw;
                      seq_recv_saved_next = !seq_recv_work;
                      read_index_next     = 10'd0;
                      phase_next          = PH_READ;
                      res_kind            = K_DONE;
                      res_cnt             = rc_new;
                    end
                  end
                end
              end else if (rx_pos >= 9'd3 && rx_pos >= 9'd3 + {1'b0, rx_len}) begin
                fl = 1'b1;
              end else begin
                rx_pos_next = rx_pos + 9'd1;
              end
            end
          end
        end
        MD_PULL: begin
          if (phase == PH_SEND) begin
            res_kind      = K_TX;
            res_data      = tx_data;
            res_last      = tx_lo;
            tx_check_next = tx_check ^ tx_data;
            if (tx_lo) begin
              phase_next    = PH_RECV;
              rx_pos_next   = 9'd0;
              rx_check_next = 8'd0;
            end else begin
              tx_pos_next = tx_pos + 9'd1;
            end
          end else if (phase == PH_READ) begin
            if (read_index < response_count && read_index < 10'(RESP_DEPTH)) begin
              res_kind        = K_RESP;
              res_data        = resp_rd;
              read_index_next = ri_inc;
              res_last        = (ri_inc == response_count);
            end
          end
        end
        default: begin
        end
      endcase

      // build the next I-block
      if (blk_go) begin
        chained_send_next  = ck_blk[8];
        tx_frame_kind_next = FR_IBLOCK;
        tx_pcb_next        = {1'b0, blk_seq, ck_blk[8], 5'd0};
        tx_len_next        = ck_blk[7:0];
        tx_pos_next        = 9'd0;
        tx_check_next      = 8'd0;
        phase_next         = PH_SEND;
      end
      if (fl) begin
        phase_next = PH_FAIL;
        res_kind   = K_ERR;
      end
    end
  end

  // prefetch addresses follow the next state
  assign aaddr_next = {1'b0, send_offset_next} + {2'b00, tx_pos_next - 9'd3};
  assign apdu_ra    = aaddr_next[APDU_AW-1:0];
  assign echo_ra    = 8'(tx_pos_next - 9'd3);
  assign resp_ra    = read_index_next[RESP_AW-1:0];

  // byte stores, write-first read
  always_ff @(posedge clk) begin
    if (apdu_we) apdu_mem[apdu_wa] <= wr_byte;
    apdu_rd <= (apdu_we && apdu_wa == apdu_ra) ? wr_byte : apdu_mem[apdu_ra];
  end

  always_ff @(posedge clk) begin
    if (echo_we) echo_mem[echo_wa] <= wr_byte;
    echo_rd <= (echo_we && echo_wa == echo_ra) ? wr_byte : echo_mem[echo_ra];
  end

  always_ff @(posedge clk) begin
    if (resp_we) resp_mem[resp_wa] <= wr_byte;
    resp_rd <= (resp_we && resp_wa == resp_ra) ? wr_byte : resp_mem[resp_ra];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ifsc_size      <= 8'd32;
      response_limit <= 10'd512;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_IFSC:  ifsc_size      <= cfg_wdata[7:0];
        REG_LIMIT: response_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      apdu_count     <= '0;
      send_offset    <= '0;
      response_count <= '0;
      read_index     <= '0;
      seq_send_saved <= 1'b0;
      seq_recv_saved <= 1'b0;
      seq_send_work  <= 1'b0;
      seq_recv_work  <= 1'b0;
      retry_count    <= '0;
      phase          <= PH_LOAD;
      resynch_spent  <= 1'b0;
      chained_send   <= 1'b0;
      tx_frame_kind  <= FR_IBLOCK;
      tx_pcb         <= '0;
      tx_len         <= '0;
      tx_pos         <= '0;
      tx_check       <= '0;
      rx_pcb         <= '0;
      rx_len         <= '0;
      rx_pos         <= '0;
      rx_check       <= '0;
    end else begin
      apdu_count     <= apdu_count_next;
      send_offset    <= send_offset_next;
      response_count <= response_count_next;
      read_index     <= read_index_next;
      seq_send_saved <= seq_send_saved_next;
      seq_recv_saved <= seq_recv_saved_next;
      seq_send_work  <= seq_send_work_next;
      seq_recv_work  <= seq_recv_work_next;
      retry_count    <= retry_count_next;
      phase          <= phase_next;
      resynch_spent  <= resynch_spent_next;
      chained_send   <= chained_send_next;
      tx_frame_kind  <= tx_frame_kind_next;
      tx_pcb         <= tx_pcb_next;
      tx_len         <= tx_len_next;
      tx_pos         <= tx_pos_next;
      tx_check       <= tx_check_next;
      rx_pcb         <= rx_pcb_next;
      rx_len         <= rx_len_next;
      rx_pos         <= rx_pos_next;
      rx_check       <= rx_check_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {6'd0, res_cnt, res_data};
      m_axis_tuser <= res_kind;
      m_axis_tlast <= res_last;
    end
  end

  // checks
  a_cnt_only_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != K_DONE |-> m_axis_tdata[17:8] == 10'd0)
    else $error("resp_count set without done");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_READ |-> read_index <= response_count)
    else $error("readout index past response length");

  a_tx_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SEND |-> tx_pos <= 9'd3 + {1'b0, tx_len})
    else $error("transmit position beyond frame");

endmodule

// ===== bench/t1bpe_checker.sv =====
// ----------------------------------------------------------------------------
// T=1 engine result checker
// Watches the request, result and config ports of the engine, predicts the
// result of every accepted request and compares it field by field, in order.
// ----------------------------------------------------------------------------
module t1bpe_checker
  import t1bpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [9:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
    logic [9:0] count;
  } engine_result_t;

  engine_result_t expected_results[$];

  // mirrored engine state
  logic [7:0] apdu_mem [APDU_DEPTH];
  logic [7:0] echo_mem [MAX_INF];
  logic [7:0] resp_mem [RESP_DEPTH];
  logic [2:0] ph;
  logic [1:0] frame_kind;
  int ifsc_reg, limit_reg;
  int apdu_n, send_off, ns_saved, nr_saved, ns_work, nr_work;
  int retries, resynch_taken, chained;
  int tx_pcb, tx_len, tx_pos, tx_lrc;
  int rx_pos, rx_pcb, rx_len, rx_lrc;
  int resp_n, rd_idx;

  function automatic logic [2:0] abort_exchange();
    ph = PH_FAIL;
    return K_ERR;
  endfunction

  function automatic int ifsc_eff();
    if (ifsc_reg == 0) return 1;
    if (ifsc_reg > MAX_INF) return MAX_INF;
    return ifsc_reg;
  endfunction

  function automatic int capacity_eff();
    return (limit_reg > RESP_DEPTH) ? RESP_DEPTH : limit_reg;
  endfunction

  function automatic int chunk_len();
    int rem;
    rem = (apdu_n > send_off) ? apdu_n - send_off : 0;
    return (rem > ifsc_eff()) ? ifsc_eff() : rem;
  endfunction

  function automatic void begin_frame(logic [1:0] k, int pcb, int len);
    frame_kind = k;
    tx_pcb = pcb & 8'hFF;
    tx_len = len & 8'hFF;
    tx_pos = 0;
    tx_lrc = 0;
    ph = PH_SEND;
  endfunction

  function automatic void build_iblock();
    int rem;
    int chunk;
    rem = (apdu_n > send_off) ? apdu_n - send_off : 0;
    chunk = chunk_len();
    chained = (chunk < rem) ? 1 : 0;
    begin_frame(FR_IBLOCK, (ns_work << 6) | (chained ? 8'h20 : 0), chunk);
  endfunction

  // a complete, well-formed card frame
  function automatic logic [2:0] close_card_frame();
    int p;
    int len;
    p = rx_pcb;
    len = rx_len;
    if (frame_kind == FR_RESYNCH) begin
      if (p != PCB_RESYNCH_RSP || len != 0) return abort_exchange();
      resynch_taken = 1;
      retries = 0;
      send_off = 0;
      resp_n = 0;
      ns_work = 0;
      nr_work = 0;
      build_iblock();
      return K_NONE;
    end
    // S-request from the card: echo it
    if ((p & 8'hC0) == 8'hC0 && (p & 8'h20) == 0) begin
      begin_frame(FR_ECHO, p | 8'h20, len);
      return K_NONE;
    end
    if (send_off < apdu_n) begin
      if ((p & 8'hC0) == PCB_R_BLOCK) begin
        if ((p & 8'h0F) != 0) begin
          // NAK
          if (((p >> 4) & 1) != ns_work) return abort_exchange();
          if (retries < MAX_RETRIES) begin
            retries++;
            build_iblock();
            return K_NONE;
          end
          if (resynch_taken) return abort_exchange();
          begin_frame(FR_RESYNCH, PCB_RESYNCH_REQ, 0);
          return K_NONE;
        end
        if (((p >> 4) & 1) != (ns_work ^ 1) || !chained) return abort_exchange();
        send_off += chunk_len();
        ns_work ^= 1;
        retries = 0;
        build_iblock();
        return K_NONE;
      end
      if ((p & 8'h80) != 0 || chained || ((p >> 6) & 1) != nr_work ||
          (p & 8'h1F) != 0 || resp_n + len > capacity_eff())
        return abort_exchange();
      send_off += chunk_len();
      ns_work ^= 1;
    end else begin
      if ((p & 8'h80) != 0 || (p & 8'h1F) != 0 || ((p >> 6) & 1) != nr_work ||
          resp_n + len > capacity_eff())
        return abort_exchange();
    end
    resp_n += len;
    nr_work ^= 1;
    if ((p & 8'h20) != 0) begin
      begin_frame(FR_ACK, PCB_R_BLOCK | (nr_work << 4), 0);
      return K_NONE;
    end
    ns_saved = ns_work;
    nr_saved = nr_work;
    rd_idx = 0;
    ph = PH_READ;
    return K_DONE;
  endfunction

  function automatic logic [2:0] take_card_byte(int b, logic lst);
    int pos;
    int i;
    pos = rx_pos;
    rx_lrc ^= b;
    if (pos == 0) begin
      if (b != 0) return abort_exchange();
    end else if (pos == 1) begin
      rx_pcb = b;
    end else if (pos == 2) begin
      if (b > MAX_INF) return abort_exchange();
      rx_len = b;
    end else begin
      i = pos - 3;
      if (i < rx_len) begin
        if (i < MAX_INF) echo_mem[i] = b[7:0];
        if (resp_n + i < RESP_DEPTH) resp_mem[resp_n + i] = b[7:0];
      end
    end
    if (lst) begin
      if (pos < 3 || pos != 3 + rx_len || rx_lrc != 0) return abort_exchange();
      return close_card_frame();
    end
    if (pos >= 3 && pos >= 3 + rx_len) return abort_exchange();
    rx_pos = pos + 1;
    return K_NONE;
  endfunction

  function automatic engine_result_t predict_result(logic [1:0] md, logic [7:0] b, logic lst);
    engine_result_t r;
    int pos;
    int i;
    r = '0;
    if (md == MD_APDU) begin
      if (ph == PH_READ || ph == PH_FAIL) begin
        apdu_n = 0;
        ph = PH_LOAD;
      end
      if (ph == PH_LOAD) begin
        if (apdu_n >= APDU_DEPTH) begin
          r.kind = abort_exchange();
        end else begin
          apdu_mem[apdu_n] = b;
          apdu_n++;
          if (lst) begin
            if (ifsc_reg == 0 || ifsc_reg > MAX_INF) begin
              r.kind = abort_exchange();
            end else begin
              ns_work = ns_saved;
              nr_work = nr_saved;
              send_off = 0;
              retries = 0;
              resynch_taken = 0;
              resp_n = 0;
              rd_idx = 0;
              build_iblock();
            end
          end
        end
      end
    end else if (md == MD_CARD) begin
      if (ph == PH_RECV) r.kind = take_card_byte(b, lst);
    end else if (md == MD_PULL) begin
      if (ph == PH_SEND) begin
        pos = tx_pos;
        r.kind = K_TX;
        if (pos == 0) r.data = 8'h00;
        else if (pos == 1) r.data = tx_pcb[7:0];
        else if (pos == 2) r.data = tx_len[7:0];
        else if (pos < 3 + tx_len) begin
          i = pos - 3;
          if (frame_kind == FR_ECHO) r.data = (i < MAX_INF) ? echo_mem[i] : 8'h00;
          else r.data = (send_off + i < APDU_DEPTH) ? apdu_mem[send_off + i] : 8'h00;
        end else begin
          r.data = tx_lrc[7:0];
          r.last = 1'b1;
        end
        tx_lrc ^= r.data;
        if (r.last) begin
          ph = PH_RECV;
          rx_pos = 0;
          rx_lrc = 0;
        end else begin
          tx_pos = pos + 1;
        end
      end else if (ph == PH_READ) begin
        if (rd_idx < resp_n && rd_idx < RESP_DEPTH) begin
          r.kind = K_RESP;
          r.data = resp_mem[rd_idx];
          rd_idx++;
          r.last = (rd_idx == resp_n);
        end
      end
    end
    if (r.kind == K_DONE) r.count = resp_n[9:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  // results are compared before the request of the same edge is predicted
  always @(posedge clk) begin
    engine_result_t exp_r;
    engine_result_t act_r;
    if (rst) begin
      expected_results.delete();
      fail_count <= 0;
      ifsc_reg = 32;
      limit_reg = 512;
      ph = PH_LOAD;
      frame_kind = FR_IBLOCK;
      apdu_n = 0; send_off = 0;
      ns_saved = 0; nr_saved = 0; ns_work = 0; nr_work = 0;
      retries = 0; resynch_taken = 0; chained = 0;
      tx_pcb = 0; tx_len = 0; tx_pos = 0; tx_lrc = 0;
      rx_pos = 0; rx_pcb = 0; rx_len = 0; rx_lrc = 0;
      resp_n = 0; rd_idx = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        act_r.kind  = m_axis_tuser;
        act_r.data  = m_axis_tdata[7:0];
        act_r.last  = m_axis_tlast;
        act_r.count = m_axis_tdata[17:8];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d data=%02h last=%0d count=%0d",
                   $time, act_r.kind, act_r.data, act_r.last, act_r.count);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== act_r || m_axis_tdata[23:18] !== 6'd0) begin
            $display("%0t: result mismatch expected kind=%0d data=%02h last=%0d count=%0d",
                     $time, exp_r.kind, exp_r.data, exp_r.last, exp_r.count);
            $display("%0t:                 actual kind=%0d data=%02h last=%0d count=%0d pad=%02h",
                     $time, act_r.kind, act_r.data, act_r.last, act_r.count,
                     m_axis_tdata[23:18]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_result(s_axis_tuser, s_axis_tdata, s_axis_tlast));
      if (cfg_wr_en) begin
        if (cfg_addr == REG_IFSC) ifsc_reg = cfg_wdata[7:0];
        else limit_reg = cfg_wdata;
      end
    end
  end

endmodule

// ===== bench/tb_t1_block_protocol_engine_top.sv =====
// ----------------------------------------------------------------------------
// T=1 engine testbench
// Runs APDU exchanges against a reactive card model: chained I-blocks, ACKs,
// NAK retries and RESYNCH, S-request echoes, chained responses, corrupted
// frames and stray requests, under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_t1_block_protocol_engine_top;
  import t1bpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_wr_en;
  logic        cfg_addr;
  logic [9:0]  cfg_wdata;
  int          fail_count;
  int          pending;

  // request/result bookkeeping
  int          req_sent;
  int          res_seen;
  logic [2:0]  res_kind;
  logic [7:0]  res_data;
  logic        res_last;
  bit          quiet;
  bit          hold_req;
  int          idle_cycles;
  int          n_exchanges, n_done, n_err, n_resynch;
  bit          card_seq, card_seq_saved;

  t1_block_protocol_engine_top u_dut (.*);

  t1bpe_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // track the last result seen by the sender side
  always @(posedge clk) begin
    if (rst) begin
      res_seen <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      res_seen <= res_seen + 1;
      res_kind <= m_axis_tuser;
      res_data <= m_axis_tdata[7:0];
      res_last <= m_axis_tlast;
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_req = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (250) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 80) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(15, 45)) @(posedge clk);
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 3) != 0);
        @(posedge clk);
      end
    end
  end

  task automatic push_req(logic [1:0] md, logic [7:0] b, logic lst);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= md;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    req_sent++;
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (res_seen != req_sent) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    wait_results();
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // pull one host frame; bytes land in frame_bytes
  task automatic pull_frame(ref logic [7:0] frame_bytes[$]);
    frame_bytes.delete();
    for (int k = 0; k < 300; k++) begin
      push_req(MD_PULL, 8'($urandom), 1'($urandom));
      wait_results();
      if (res_kind != K_TX) break;
      frame_bytes.push_back(res_data);
      if (res_last) break;
    end
  endtask

  // card frame; fault: 0 clean, 1 NAD, 2 LRC, 3 short, 4 long, 5 LEN too big
  task automatic send_card(logic [7:0] pcb, int len, int fault);
    logic [7:0] q[$];
    logic [7:0] lrc;
    q = {8'h00, pcb, 8'(len)};
    for (int k = 0; k < len; k++) q.push_back(8'($urandom));
    lrc = 8'h00;
    foreach (q[k]) lrc ^= q[k];
    q.push_back(lrc);
    case (fault)
      1: q[0] = 8'($urandom_range(1, 255));
      2: q[q.size() - 1] ^= 8'(1 << $urandom_range(0, 7));
      3: void'(q.pop_back());
      4: q.push_back(8'($urandom));
      5: q[2] = 8'($urandom_range(MAX_INF + 1, 255));
      default: ;
    endcase
    // stray requests the engine must ignore while it waits for the card
    if ($urandom_range(0, 9) == 0)
      push_req($urandom_range(0, 1) ? MD_SPARE : MD_PULL, 8'($urandom), 1'($urandom));
    foreach (q[k]) push_req(MD_CARD, q[k], k == q.size() - 1);
    wait_results();
  endtask

  task automatic read_response();
    for (int k = 0; k < RESP_DEPTH + 2; k++) begin
      push_req(MD_PULL, 8'($urandom), 1'($urandom));
      wait_results();
      if (res_kind != K_RESP || res_last) break;
    end
    if ($urandom_range(0, 2) == 0) begin
      push_req(MD_PULL, 8'($urandom), 1'b0);
      wait_results();
    end
  endtask

  // one full APDU exchange with a reactive card
  task automatic run_exchange(int n, int nak_pct, int bad_pct);
    logic [7:0] frame_bytes[$];
    logic [7:0] hp, rp, pcb;
    int len;
    int fault;
    n_exchanges++;
    card_seq = card_seq_saved;
    rp = 8'h00;
    for (int k = 0; k < n; k++) push_req(MD_APDU, 8'($urandom), k == n - 1);
    wait_results();
    if (res_kind == K_ERR) begin
      n_err++;
      return;
    end
    for (int f = 0; f < 40; f++) begin
      pull_frame(frame_bytes);
      if (frame_bytes.size() < 3) return;
      hp = frame_bytes[1];
      fault = ($urandom_range(0, 99) < bad_pct) ? $urandom_range(1, 5) : 0;
      len = 0;
      if (hp == PCB_RESYNCH_REQ) begin
        n_resynch++;
        card_seq = 1'b0;
        pcb = PCB_RESYNCH_RSP;
      end else begin
        if ((hp & 8'hE0) != 8'hE0) rp = hp;
        if ($urandom_range(0, 7) == 0) begin
          // S-request from the card
          pcb = 8'hC0 | 8'($urandom_range(0, 3));
          len = $urandom_range(0, 3);
        end else if (!rp[7] && $urandom_range(0, 99) < nak_pct) begin
          pcb = PCB_R_BLOCK | {3'b000, rp[6], 4'($urandom_range(1, 15))};
        end else if (!rp[7] && rp[5]) begin
          pcb = PCB_R_BLOCK | {3'b000, ~rp[6], 4'h0};
        end else begin
          // card I-block, sometimes chained
          pcb = {1'b0, card_seq, 1'b0, 5'h00};
          if ($urandom_range(0, 2) == 0) pcb[5] = 1'b1;
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
          if (fault == 0) card_seq = ~card_seq;
        end
      end
      send_card(pcb, len, fault);
      if (res_kind == K_DONE) begin
        n_done++;
        card_seq_saved = card_seq;
        read_response();
        return;
      end
      if (res_kind == K_ERR) begin
        n_err++;
        return;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = REG_IFSC;
    cfg_wdata = '0;
    quiet = 1'b0;
    req_sent = 0;
    n_exchanges = 0; n_done = 0; n_err = 0; n_resynch = 0;
    card_seq_saved = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ignored requests at idle, extremes of IFSC and limit
    push_req(MD_SPARE, 8'hFF, 1'b1);
    push_req(MD_CARD, 8'h00, 1'b1);
    push_req(MD_PULL, 8'hA5, 1'b0);
    write_reg(REG_IFSC, 10'd1);
    run_exchange(3, 0, 0);
    write_reg(REG_IFSC, 10'd254);
    run_exchange(2, 100, 0);
    write_reg(REG_IFSC, 10'd0);
    run_exchange(1, 0, 0);
    write_reg(REG_IFSC, 10'h3FF);
    run_exchange(1, 0, 0);
    write_reg(REG_IFSC, 10'd4);
    write_reg(REG_LIMIT, 10'd0);
    run_exchange(2, 0, 0);
    write_reg(REG_LIMIT, 10'h3FF);
    hold_req = 1'b1;
    run_exchange(16, 10, 0);

    // random exchanges
    while (req_sent < 360) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_IFSC, ($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, 1023))
                                                         : 10'($urandom_range(1, 16)));
      if ($urandom_range(0, 3) == 0)
        case ($urandom_range(0, 3))
          0: write_reg(REG_LIMIT, 10'($urandom_range(0, 40)));
          1: write_reg(REG_LIMIT, 10'($urandom_range(0, 1023)));
          default: write_reg(REG_LIMIT, 10'd512);
        endcase
      run_exchange(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24),
                   $urandom_range(0, 1) ? 15 : 40, 6);
    end

    wait_results();
    repeat (10) @(posedge clk);
    $display("Run covered %0d requests over %0d exchanges: %0d completed, %0d errored,",
             req_sent, n_exchanges, n_done, n_err);
    $display("%0d resynch frames, with random stalls and one long receiver hold-off.",
             n_resynch);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/t1bpe_pkg.sv
design/t1_block_protocol_engine_top.sv
bench/t1bpe_checker.sv
bench/tb_t1_block_protocol_engine_top.sv
